@@ rtl/core/disk_overlap_relaxation_sweep_defines.svh @@
// Assertion macros used by the RTL in dors_ctrl
`ifndef DISK_OVERLAP_RELAXATION_SWEEP_DEFINES_SVH
`define DISK_OVERLAP_RELAXATION_SWEEP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define DORS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define DORS_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

@@ rtl/core/dors_pkg.sv @@
// ----------------------------------------------------------------------------
// dors_pkg
// Shared types and codes for the disk overlap relaxation sweep.
// ----------------------------------------------------------------------------
`default_nettype none
package dors_pkg;
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_SWEEP  = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] CFG_SQUARE = 2'd0;
    localparam logic [1:0] CFG_DAMP   = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_APPEND,
        OP_RD_ISSUE,
        OP_RD_LATCH,
        OP_I_ISSUE,
        OP_I_LATCH,
        OP_I_DAMP,
        OP_I_WALL,
        OP_J_ISSUE,
        OP_J_MUL,
        OP_J_CMP,
        OP_J_WRITE,
        OP_I_MOVE,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic rd_bad;
        logic n_zero;
        logic i_last;
        logic j_last;
        logic j_self;
        logic hit;
    } t_stat;
endpackage
`default_nettype wire

@@ rtl/core/dors_ctrl.sv @@
// ----------------------------------------------------------------------------
// dors_ctrl
// Command sequencer: decodes a transaction and steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "disk_overlap_relaxation_sweep_defines.svh"
module dors_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [1:0]    i_command,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output dors_pkg::t_cmd     o_cmd,
    input  wire dors_pkg::t_stat i_stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_I0, S_I1, S_I2, S_I3,
        S_J0, S_J1, S_J2, S_J3, S_MOVE, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_acc;

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;
    assign w_acc       = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd.op = dors_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_command)
                        dors_pkg::CMD_CLEAR:  o_cmd.op = dors_pkg::OP_CLEAR;
                        dors_pkg::CMD_APPEND: o_cmd.op = dors_pkg::OP_APPEND;
                        dors_pkg::CMD_SWEEP:  o_cmd.op = dors_pkg::OP_FINISH;
                        dors_pkg::CMD_READ:   o_cmd.op = dors_pkg::OP_RD_ISSUE;
                        default:              o_cmd.op = dors_pkg::OP_NONE;
                    endcase
                end
            end
            S_RD0:  o_cmd.op = dors_pkg::OP_RD_LATCH;
            S_RD1:  o_cmd.op = dors_pkg::OP_NONE;
            S_I0:   o_cmd.op = dors_pkg::OP_I_ISSUE;
            S_I1:   o_cmd.op = dors_pkg::OP_I_LATCH;
            S_I2:   o_cmd.op = dors_pkg::OP_I_DAMP;
            S_I3:   o_cmd.op = dors_pkg::OP_I_WALL;
            S_J0:   o_cmd.op = dors_pkg::OP_J_ISSUE;
            S_J1:   o_cmd.op = dors_pkg::OP_J_MUL;
            S_J2:   o_cmd.op = dors_pkg::OP_J_CMP;
            S_J3:   o_cmd.op = dors_pkg::OP_J_WRITE;
            S_MOVE: o_cmd.op = dors_pkg::OP_I_MOVE;
            S_FIN:  o_cmd.op = dors_pkg::OP_NONE;
            S_OUT:  o_cmd.op = dors_pkg::OP_NONE;
            default: o_cmd.op = dors_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        priority case (i_command)
                            dors_pkg::CMD_READ:  r_state <= S_RD0;
                            dors_pkg::CMD_SWEEP: r_state <= i_stat.n_zero ? S_OUT : S_I0;
                            default:             r_state <= S_OUT;
                        endcase
                    end
                end
                S_RD0:  r_state <= S_RD1;
                S_RD1:  r_state <= S_OUT;
                S_I0:   r_state <= S_I1;
                S_I1:   r_state <= S_I2;
                S_I2:   r_state <= S_I3;
                S_I3:   r_state <= S_J0;
                S_J0:   r_state <= i_stat.j_self ? (i_stat.j_last ? S_MOVE : S_J0) : S_J1;
                S_J1:   r_state <= S_J2;
                S_J2:   r_state <= i_stat.hit ? S_J3 : (i_stat.j_last ? S_MOVE : S_J0);
                S_J3:   r_state <= i_stat.j_last ? S_MOVE : S_J0;
                S_MOVE: r_state <= i_stat.i_last ? S_FIN : S_I0;
                S_FIN:  r_state <= S_OUT;
                S_OUT: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `DORS_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !w_acc)
    `DORS_ASSERT_NXT(a_out_after, i_clk, i_rst_n, r_state == S_OUT, r_out_valid)
    `DORS_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)
endmodule
`default_nettype wire

@@ rtl/core/dors_dp.sv @@
// ----------------------------------------------------------------------------
// dors_dp
// Disk table memories, pair arithmetic and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module dors_dp #(
    parameter int MAX_DISKS = 1024,
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dors_pkg::t_cmd     i_cmd,
    output dors_pkg::t_stat         o_stat,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [16:0]        i_cfg_data,
    input  wire logic signed [27:0] i_pos_x,
    input  wire logic signed [27:0] i_pos_y,
    input  wire logic [5:0]         i_disk_radius,
    input  wire logic [9:0]         i_disk_index,
    input  wire logic [19:0]        i_push_step,
    input  wire logic               i_out_take,
    output logic [1:0]              o_status,
    output logic signed [27:0]      o_out_x,
    output logic signed [27:0]      o_out_y,
    output logic signed [31:0]      o_out_vx,
    output logic signed [31:0]      o_out_vy,
    output logic [5:0]              o_out_radius,
    output logic [19:0]             o_overlap_count,
    output logic [10:0]             o_disk_total
);
    localparam int AW = $clog2(MAX_DISKS);
    localparam int CW = $clog2(MAX_DISKS + 1);
    localparam logic signed [63:0] VMAX = 64'sd2147483647;
    localparam logic signed [63:0] VMIN = -64'sd2147483648;
    localparam logic signed [63:0] PMAX = 64'sd134217727;
    localparam logic signed [63:0] PMIN = -64'sd134217728;

    logic signed [27:0] m_x  [MAX_DISKS];
    logic signed [27:0] m_y  [MAX_DISKS];
    logic signed [31:0] m_vx [MAX_DISKS];
    logic signed [31:0] m_vy [MAX_DISKS];
    logic [5:0]         m_r  [MAX_DISKS];

    logic [9:0]  r_square;
    logic [16:0] r_damp;
    logic        r_mode;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_i, r_j;
    logic [AW-1:0] r_rd_addr;
    logic signed [27:0] r_rx, r_ry;
    logic signed [31:0] r_rvx, r_rvy;
    logic [5:0]  r_rr;
    logic signed [27:0] r_xi, r_yi;
    logic signed [31:0] r_vxi, r_vyi;
    logic [5:0]  r_ri;
    logic signed [63:0] r_px, r_py;
    logic signed [63:0] r_dx2, r_dy2, r_rs2;
    logic [19:0] r_hits;
    logic [19:0] r_push;
    logic        r_hit;
    logic        r_rd_bad;
    logic [1:0]  r_status;
    logic signed [27:0] r_ox, r_oy;
    logic signed [31:0] r_ovx, r_ovy;
    logic [5:0]  r_orad;
    logic [19:0] r_ocnt;

    logic signed [63:0] w_hi, w_lo, w_dx, w_dy, w_rs;
    logic signed [63:0] w_vxi, w_vyi, w_vxj, w_vyj, w_xi, w_yi;
    logic signed [63:0] w_push;
    logic w_xlt, w_ylt;

    function automatic logic signed [31:0] satv(input logic signed [63:0] v);
        if (v > VMAX) return 32'sh7FFFFFFF;
        if (v < VMIN) return 32'sh80000000;
        return v[31:0];
    endfunction
    function automatic logic signed [27:0] satp(input logic signed [63:0] v);
        if (v > PMAX) return 28'sh7FFFFFF;
        if (v < PMIN) return 28'sh8000000;
        return v[27:0];
    endfunction
    function automatic logic signed [31:0] shdamp(input logic signed [63:0] p);
        logic signed [63:0] a;
        if (p < 0) begin
            a = -p;
            return satv(-(a >>> 16));
        end
        return satv(p >>> 16);
    endfunction

    assign w_hi = ($signed({54'd0, r_square}) - $signed({58'd0, r_ri})) <<< FRAC_BITS;
    assign w_lo = $signed({58'd0, r_ri}) <<< FRAC_BITS;
    assign w_dx = 64'(r_xi) - 64'(r_rx);
    assign w_dy = 64'(r_yi) - 64'(r_ry);
    assign w_rs = ($signed({58'd0, r_ri}) + $signed({58'd0, r_rr})) <<< FRAC_BITS;
    assign w_push = $signed({44'd0, r_push});
    assign w_xlt = r_xi < r_rx;
    assign w_ylt = r_yi < r_ry;
    assign w_vxi = w_xlt ? 64'(r_vxi) - w_push : 64'(r_vxi) + w_push;
    assign w_vxj = w_xlt ? 64'(r_rvx) + w_push : 64'(r_rvx) - w_push;
    assign w_vyi = w_ylt ? 64'(r_vyi) - w_push : 64'(r_vyi) + w_push;
    assign w_vyj = w_ylt ? 64'(r_rvy) + w_push : 64'(r_rvy) - w_push;
    always_comb begin
        w_xi = 64'(r_xi);
        if (w_xi > w_hi) w_xi = 64'(satp(w_hi));
        if (w_xi < w_lo) w_xi = 64'(satp(w_lo));
        w_yi = 64'(r_yi);
        if (w_yi > w_hi) w_yi = 64'(satp(w_hi));
        if (w_yi < w_lo) w_yi = 64'(satp(w_lo));
    end

    always_comb begin
        o_stat.full   = r_count >= CW'(MAX_DISKS);
        o_stat.rd_bad = r_rd_bad;
        o_stat.n_zero = r_count == '0;
        o_stat.i_last = {1'b0, r_i} == r_count - 1'b1;
        o_stat.j_last = {1'b0, r_j} == r_count - 1'b1;
        o_stat.j_self = r_j == r_i;
        o_stat.hit    = (r_dx2 + r_dy2) < r_rs2;
    end

    // memories: one port read, one port written
    always_ff @(posedge i_clk) begin
        logic [AW-1:0] ra;
        ra = r_j;
        unique case (i_cmd.op)
            dors_pkg::OP_APPEND: begin
                if (r_count < CW'(MAX_DISKS)) begin
                    m_x[r_count[AW-1:0]]  <= i_pos_x;
                    m_y[r_count[AW-1:0]]  <= i_pos_y;
                    m_vx[r_count[AW-1:0]] <= '0;
                    m_vy[r_count[AW-1:0]] <= '0;
                    m_r[r_count[AW-1:0]]  <= i_disk_radius;
                end
            end
            dors_pkg::OP_J_WRITE: begin
                m_vx[r_j] <= satv(w_vxj);
                m_vy[r_j] <= satv(w_vyj);
            end
            dors_pkg::OP_I_MOVE: begin
                m_vx[r_i] <= r_vxi;
                m_vy[r_i] <= r_vyi;
                if (!r_mode || r_hits != '0) begin
                    m_x[r_i] <= satp(64'(r_xi) + 64'(r_vxi));
                    m_y[r_i] <= satp(64'(r_yi) + 64'(r_vyi));
                end else begin
                    m_x[r_i] <= r_xi;
                    m_y[r_i] <= r_yi;
                end
            end
            default: ;
        endcase
        if (i_cmd.op == dors_pkg::OP_RD_LATCH) ra = r_rd_addr;
        if (i_cmd.op == dors_pkg::OP_I_ISSUE) ra = r_i;
        r_rx  <= m_x[ra];
        r_ry  <= m_y[ra];
        r_rvx <= m_vx[ra];
        r_rvy <= m_vy[ra];
        r_rr  <= m_r[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square <= 10'd775;
            r_damp   <= 17'd62259;
            r_mode   <= 1'b1;
            r_count  <= '0;
            r_status <= dors_pkg::ST_OK;
            r_ocnt   <= '0;
            r_ox <= '0; r_oy <= '0; r_ovx <= '0; r_ovy <= '0; r_orad <= '0;
            r_i <= '0; r_j <= '0; r_hits <= '0; r_rd_bad <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dors_pkg::CFG_SQUARE: r_square <= i_cfg_data[9:0];
                    dors_pkg::CFG_DAMP:   r_damp   <= i_cfg_data;
                    dors_pkg::CFG_MODE:   r_mode   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (i_cmd.op)
                dors_pkg::OP_CLEAR: begin
                    r_count <= '0;
                    r_status <= dors_pkg::ST_OK;
                    r_ocnt <= '0;
                    r_ox <= '0; r_oy <= '0; r_ovx <= '0; r_ovy <= '0; r_orad <= '0;
                end
                dors_pkg::OP_APPEND: begin
                    r_ocnt <= '0;
                    r_ox <= '0; r_oy <= '0; r_ovx <= '0; r_ovy <= '0; r_orad <= '0;
                    if (r_count >= CW'(MAX_DISKS)) r_status <= dors_pkg::ST_FULL;
                    else begin
                        r_status <= dors_pkg::ST_OK;
                        r_count <= r_count + 1'b1;
                    end
                end
                dors_pkg::OP_RD_ISSUE: begin
                    r_rd_bad  <= 32'(i_disk_index) >= 32'(r_count);
                    r_rd_addr <= AW'(i_disk_index);
                end
                dors_pkg::OP_RD_LATCH: begin
                    r_ocnt <= '0;
                end
                dors_pkg::OP_FINISH: begin
                    r_i <= '0; r_j <= '0; r_hits <= '0;
                    r_push <= i_push_step;
                    r_status <= dors_pkg::ST_OK;
                    r_ocnt <= '0;
                    r_ox <= '0; r_oy <= '0; r_ovx <= '0; r_ovy <= '0; r_orad <= '0;
                end
                dors_pkg::OP_I_ISSUE: r_j <= '0;
                dors_pkg::OP_I_LATCH: begin
                    r_xi <= r_rx; r_yi <= r_ry; r_ri <= r_rr;
                    r_px <= 64'(r_rvx) * $signed({47'd0, r_damp});
                    r_py <= 64'(r_rvy) * $signed({47'd0, r_damp});
                end
                dors_pkg::OP_I_DAMP: begin
                    r_vxi <= shdamp(r_px);
                    r_vyi <= shdamp(r_py);
                end
                dors_pkg::OP_I_WALL: begin
                    if (64'(r_xi) > w_hi || 64'(r_xi) < w_lo) r_vxi <= satv(-64'(r_vxi));
                    if (64'(r_yi) > w_hi || 64'(r_yi) < w_lo) r_vyi <= satv(-64'(r_vyi));
                end
                dors_pkg::OP_J_ISSUE: begin
                    if (r_j == r_i) r_j <= r_j + 1'b1;
                end
                dors_pkg::OP_J_MUL: begin
                    r_dx2 <= w_dx * w_dx;
                    r_dy2 <= w_dy * w_dy;
                    r_rs2 <= w_rs * w_rs;
                end
                dors_pkg::OP_J_CMP: begin
                    if (!o_stat.hit) r_j <= r_j + 1'b1;
                    else if (r_hits != 20'hFFFFF) r_hits <= r_hits + 1'b1;
                end
                dors_pkg::OP_J_WRITE: begin
                    r_vxi <= satv(w_vxi);
                    r_vyi <= satv(w_vyi);
                    r_xi  <= w_xi[27:0];
                    r_yi  <= w_yi[27:0];
                    r_j   <= r_j + 1'b1;
                end
                dors_pkg::OP_I_MOVE: begin
                    r_i <= r_i + 1'b1;
                    r_ocnt <= (!r_mode || r_hits != '0) ? r_hits : r_hits;
                end
                default: ;
            endcase
            if (i_cmd.op == dors_pkg::OP_NONE && r_rd_addr == r_rd_addr
                && i_out_take) begin
                r_rd_bad <= r_rd_bad;
            end
            if (i_cmd.op == dors_pkg::OP_RD_LATCH) r_rd_bad <= r_rd_bad;
        end
    end

    // capture the read result in the cycle after the memory read
    logic r_rd_cap;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_cap <= 1'b0;
        else r_rd_cap <= i_cmd.op == dors_pkg::OP_RD_LATCH;
    end
    logic [1:0] w_status;
    assign w_status = r_rd_bad ? dors_pkg::ST_RANGE : dors_pkg::ST_OK;
    logic [1:0] r_status_q;
    logic signed [27:0] r_ox_q, r_oy_q;
    logic signed [31:0] r_ovx_q, r_ovy_q;
    logic [5:0] r_orad_q;
    always_ff @(posedge i_clk) begin
        if (r_rd_cap) begin
            r_status_q <= w_status;
            r_ox_q   <= r_rd_bad ? '0 : r_rx;
            r_oy_q   <= r_rd_bad ? '0 : r_ry;
            r_ovx_q  <= r_rd_bad ? '0 : r_rvx;
            r_ovy_q  <= r_rd_bad ? '0 : r_rvy;
            r_orad_q <= r_rd_bad ? '0 : r_rr;
        end
    end
    logic r_is_rd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_is_rd <= 1'b0;
        else if (i_cmd.op == dors_pkg::OP_RD_ISSUE) r_is_rd <= 1'b1;
        else if (i_cmd.op == dors_pkg::OP_CLEAR || i_cmd.op == dors_pkg::OP_APPEND
                 || i_cmd.op == dors_pkg::OP_FINISH) r_is_rd <= 1'b0;
    end

    assign o_status        = r_is_rd ? r_status_q : r_status;
    assign o_out_x         = r_is_rd ? r_ox_q : r_ox;
    assign o_out_y         = r_is_rd ? r_oy_q : r_oy;
    assign o_out_vx        = r_is_rd ? r_ovx_q : r_ovx;
    assign o_out_vy        = r_is_rd ? r_ovy_q : r_ovy;
    assign o_out_radius    = r_is_rd ? r_orad_q : r_orad;
    assign o_overlap_count = r_is_rd ? 20'd0 : r_ocnt;
    assign o_disk_total    = 11'(r_count);
endmodule
`default_nettype wire

@@ rtl/core/disk_overlap_relaxation_sweep.sv @@
// ----------------------------------------------------------------------------
// disk_overlap_relaxation_sweep
// Disk table with clear, append, read and relaxation sweep commands.
// ----------------------------------------------------------------------------
// Usage: an input transaction (i_in_valid, o_in_stall) carries a command and
// its operands; each command yields one output transaction (o_out_valid,
// i_out_stall) with status, read-back fields, overlap count and disk total.
// A sweep steps every ordered pair of disks through the one pair unit,
// reading the disk memories over their single read port. One command is
// in flight at a time; a new one is taken once the previous result is
// taken or no longer stalled.
// Reset clears the disk count and loads the default configuration;
// memory contents are not cleared. While the receiver stalls, the result
// holds and no new command is taken.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are taken any
// cycle and should occur only while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module disk_overlap_relaxation_sweep #(
    parameter int MAX_DISKS = 1024,
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [16:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_command,
    input  wire logic signed [27:0] i_pos_x,
    input  wire logic signed [27:0] i_pos_y,
    input  wire logic [5:0]         i_disk_radius,
    input  wire logic [9:0]         i_disk_index,
    input  wire logic [19:0]        i_push_step,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_status,
    output logic signed [27:0]      o_out_x,
    output logic signed [27:0]      o_out_y,
    output logic signed [31:0]      o_out_vx,
    output logic signed [31:0]      o_out_vy,
    output logic [5:0]              o_out_radius,
    output logic [19:0]             o_overlap_count,
    output logic [10:0]             o_disk_total
);
    dors_pkg::t_cmd  w_cmd;
    dors_pkg::t_stat w_stat;

    dors_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_command(i_command),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_cmd(w_cmd), .i_stat(w_stat)
    );

    dors_dp #(.MAX_DISKS(MAX_DISKS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_disk_radius(i_disk_radius),
        .i_disk_index(i_disk_index), .i_push_step(i_push_step),
        .i_out_take(o_out_valid && !i_out_stall),
        .o_status(o_status), .o_out_x(o_out_x), .o_out_y(o_out_y),
        .o_out_vx(o_out_vx), .o_out_vy(o_out_vy), .o_out_radius(o_out_radius),
        .o_overlap_count(o_overlap_count), .o_disk_total(o_disk_total)
    );
endmodule
`default_nettype wire
